@@ design/dia_pkg.sv @@
// Shared types and constants for the handle table allocator.
// No dependencies; imported by dia_cell, dedup_id_allocator_top and the testbench files.

package dia_pkg;

	localparam int DEF_SLOT_COUNT = 64;
	localparam int DEF_KEY_BITS   = 32;

	typedef enum logic [2:0] {
		OP_ALLOC    = 3'd0,
		OP_FREE_ID  = 3'd1,
		OP_FREE_KEY = 3'd2,
		OP_LOOKUP   = 3'd3,
		OP_CLEAR    = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_SCAN = 1'b1
	} state_t;

	// Flags of the scan token that walks the cell row
	typedef struct packed {
		logic valid;
		logic found;
		logic hole;
	} tok_flags_t;

	// Write broadcast from the controller to every cell
	typedef struct packed {
		logic en;
		logic clr;
	} wr_ctl_t;

endpackage

@@ design/dia_cell.sv @@
// One slot of the handle table: holds the slot key and a stage of the scan token.
// Depends on dia_pkg.

module dia_cell #(
	parameter int SLOT_COUNT = dia_pkg::DEF_SLOT_COUNT,
	parameter int KEY_BITS   = dia_pkg::DEF_KEY_BITS,
	parameter int IDX        = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [KEY_BITS-1:0]                key_op,
	input  logic [$clog2(SLOT_COUNT+1)-1:0]    id_op,
	input  logic [$clog2(SLOT_COUNT+1)-1:0]    size,
	input  dia_pkg::tok_flags_t                tok_in,
	input  logic [$clog2(SLOT_COUNT+1)-1:0]    fid_in,
	input  logic [$clog2(SLOT_COUNT+1)-1:0]    hid_in,
	input  logic [KEY_BITS-1:0]                rkey_in,
	output dia_pkg::tok_flags_t                tok_out,
	output logic [$clog2(SLOT_COUNT+1)-1:0]    fid_out,
	output logic [$clog2(SLOT_COUNT+1)-1:0]    hid_out,
	output logic [KEY_BITS-1:0]                rkey_out,
	input  dia_pkg::wr_ctl_t                   wr_ctl,
	input  logic [$clog2(SLOT_COUNT+1)-1:0]    wr_id,
	input  logic [KEY_BITS-1:0]                wr_key
);
	import dia_pkg::*;

	localparam int IW = $clog2(SLOT_COUNT+1);
	localparam logic [IW-1:0] SLOT_NUM = IW'(IDX + 1);

	logic [KEY_BITS-1:0] key_q;
	tok_flags_t          tok_q;
	logic [IW-1:0]       fid_q;
	logic [IW-1:0]       hid_q;
	logic [KEY_BITS-1:0] rkey_q;
	logic                in_use;
	logic                hit;
	logic                empty;

	assign in_use = (SLOT_NUM <= size);
	assign hit    = in_use && (key_op != '0) && (key_q == key_op);
	assign empty  = in_use && (key_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (wr_ctl.clr) begin
			key_q <= '0;
		end else if (wr_ctl.en && (wr_id == SLOT_NUM)) begin
			key_q <= wr_key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= tok_in.valid;
			tok_q.found <= tok_in.found || hit;
			tok_q.hole  <= tok_in.hole || empty;
		end
	end

	// Keep the first match and the first hole seen upstream
	always_ff @(posedge clk) begin
		fid_q  <= (!tok_in.found && hit) ? SLOT_NUM : fid_in;
		hid_q  <= (!tok_in.hole && empty) ? SLOT_NUM : hid_in;
		rkey_q <= (id_op == SLOT_NUM) ? key_q : rkey_in;
	end

	assign tok_out  = tok_q;
	assign fid_out  = fid_q;
	assign hid_out  = hid_q;
	assign rkey_out = rkey_q;

endmodule

@@ design/dedup_id_allocator_top.sv @@
// Top level of the handle table allocator: controller plus a row of slot cells.
// Depends on dia_pkg and dia_cell.
//
//  channel   | handshake                 | payload
//  ----------+---------------------------+-------------------------------------------
//  command   | start in, busy out        | operation, key, slot_id
//  result    | done out (one-cycle pulse)| result_id, result_key, status,
//            |                           | live_count, used_size
//
// A transaction is taken when start is high and busy low. A scan token then walks the
// cell row one cell per clock, registered in every cell, and done is registered from
// the token leaving the tail; busy falls in the cycle done is high.
// Reset clears every slot at once; no sweep follows.
// The receiver cannot stall: each result is shown for the one cycle done is high.

module dedup_id_allocator_top #(
	parameter int SLOT_COUNT = dia_pkg::DEF_SLOT_COUNT,
	parameter int KEY_BITS   = dia_pkg::DEF_KEY_BITS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [2:0]                         operation,
	input  logic [KEY_BITS-1:0]                key,
	input  logic [$clog2(SLOT_COUNT+1)-1:0]    slot_id,
	output logic                               done,
	output logic [$clog2(SLOT_COUNT+1)-1:0]    result_id,
	output logic [KEY_BITS-1:0]                result_key,
	output logic [1:0]                         status,
	output logic [$clog2(SLOT_COUNT+1)-1:0]    live_count,
	output logic [$clog2(SLOT_COUNT+1)-1:0]    used_size
);
	import dia_pkg::*;

	localparam int IW = $clog2(SLOT_COUNT+1);

	state_t              state_q, state_d;
	logic                accept;
	logic                launch_q;
	op_t                 op_q;
	logic [KEY_BITS-1:0] key_q;
	logic [IW-1:0]       id_q;
	logic [IW-1:0]       size_q, size_d;
	logic [IW-1:0]       count_q, count_d;

	tok_flags_t          tok_c  [0:SLOT_COUNT];
	logic [IW-1:0]       fid_c  [0:SLOT_COUNT];
	logic [IW-1:0]       hid_c  [0:SLOT_COUNT];
	logic [KEY_BITS-1:0] rkey_c [0:SLOT_COUNT];

	wr_ctl_t             wr_ctl;
	logic [IW-1:0]       wr_id;
	logic [KEY_BITS-1:0] wr_key;

	tok_flags_t          tok_end;
	logic                id_ok;
	logic [IW-1:0]       fin_rid;
	logic [KEY_BITS-1:0] fin_rkey;
	status_t             fin_st;

	logic                done_q;
	logic [IW-1:0]       result_id_q;
	logic [KEY_BITS-1:0] result_key_q;
	status_t             status_q;

	assign tok_end = tok_c[SLOT_COUNT];

	// Controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b1;
		accept  = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy   = 1'b0;
				accept = start;
				if (start) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (tok_end.valid) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			launch_q <= 1'b0;
		end else begin
			launch_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_t'(operation);
			key_q <= key;
			id_q  <= slot_id;
		end
	end

	// Cell row; the token enters at the head in the cycle after the accept
	assign tok_c[0]  = '{valid: launch_q, found: 1'b0, hole: 1'b0};
	assign fid_c[0]  = '0;
	assign hid_c[0]  = '0;
	assign rkey_c[0] = '0;

	for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_cell
		dia_cell #(
			.SLOT_COUNT(SLOT_COUNT),
			.KEY_BITS  (KEY_BITS),
			.IDX       (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.key_op  (key_q),
			.id_op   (id_q),
			.size    (size_q),
			.tok_in  (tok_c[i]),
			.fid_in  (fid_c[i]),
			.hid_in  (hid_c[i]),
			.rkey_in (rkey_c[i]),
			.tok_out (tok_c[i+1]),
			.fid_out (fid_c[i+1]),
			.hid_out (hid_c[i+1]),
			.rkey_out(rkey_c[i+1]),
			.wr_ctl  (wr_ctl),
			.wr_id   (wr_id),
			.wr_key  (wr_key)
		);
	end

	// Resolve the transaction when the token leaves the tail
	assign id_ok = (id_q != '0) && (id_q <= size_q);

	always_comb begin
		wr_ctl   = '0;
		wr_id    = '0;
		wr_key   = '0;
		fin_rid  = '0;
		fin_rkey = '0;
		fin_st   = ST_IGNORED;
		size_d   = size_q;
		count_d  = count_q;
		if (tok_end.valid) begin
			case (op_q)
				OP_ALLOC: begin
					if (key_q != '0) begin
						if (tok_end.found) begin
							fin_rid = fid_c[SLOT_COUNT];
							fin_st  = ST_DONE;
						end else if (tok_end.hole) begin
							wr_ctl.en = 1'b1;
							wr_id     = hid_c[SLOT_COUNT];
							wr_key    = key_q;
							count_d   = IW'(count_q + 1'b1);
							fin_rid   = hid_c[SLOT_COUNT];
							fin_st    = ST_DONE;
						end else if (size_q < IW'(SLOT_COUNT)) begin
							wr_ctl.en = 1'b1;
							wr_id     = IW'(size_q + 1'b1);
							wr_key    = key_q;
							size_d    = IW'(size_q + 1'b1);
							count_d   = IW'(count_q + 1'b1);
							fin_rid   = IW'(size_q + 1'b1);
							fin_st    = ST_DONE;
						end else begin
							fin_st = ST_FULL;
						end
					end
				end
				OP_FREE_ID: begin
					if (id_ok && (rkey_c[SLOT_COUNT] != '0)) begin
						wr_ctl.en = 1'b1;
						wr_id     = id_q;
						count_d   = IW'(count_q - 1'b1);
						fin_st    = ST_DONE;
					end
				end
				OP_FREE_KEY: begin
					if ((key_q != '0) && id_ok && tok_end.found) begin
						wr_ctl.en = 1'b1;
						wr_id     = fid_c[SLOT_COUNT];
						count_d   = IW'(count_q - 1'b1);
						fin_st    = ST_DONE;
					end
				end
				OP_LOOKUP: begin
					if (id_ok && (rkey_c[SLOT_COUNT] != '0)) begin
						fin_rkey = rkey_c[SLOT_COUNT];
						fin_st   = ST_DONE;
					end
				end
				OP_CLEAR: begin
					wr_ctl.clr = 1'b1;
					count_d    = '0;
					fin_st     = ST_DONE;
				end
				default: fin_st = ST_IGNORED;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			size_q  <= size_d;
			count_q <= count_d;
			done_q  <= tok_end.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_end.valid) begin
			result_id_q  <= fin_rid;
			result_key_q <= fin_rkey;
			status_q     <= fin_st;
		end
	end

	assign done       = done_q;
	assign result_id  = result_id_q;
	assign result_key = result_key_q;
	assign status     = status_q;
	assign live_count = count_q;
	assign used_size  = size_q;

endmodule

@@ tb/sv/dedup_id_allocator_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the handle table allocator: keeps a shadow slot table, predicts the
// reply to every accepted command and compares it with the strobed result.
// Depends on dia_pkg.

module dedup_id_allocator_checker #(
	parameter int SLOT_COUNT = dia_pkg::DEF_SLOT_COUNT,
	parameter int KEY_BITS   = dia_pkg::DEF_KEY_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [2:0]                      operation,
	input  logic [KEY_BITS-1:0]             key,
	input  logic [$clog2(SLOT_COUNT+1)-1:0] slot_id,
	input  logic                            done,
	input  logic [$clog2(SLOT_COUNT+1)-1:0] result_id,
	input  logic [KEY_BITS-1:0]             result_key,
	input  logic [1:0]                      status,
	input  logic [$clog2(SLOT_COUNT+1)-1:0] live_count,
	input  logic [$clog2(SLOT_COUNT+1)-1:0] used_size,
	output int                              fail_count,
	output int                              pending
);
	import dia_pkg::*;

	localparam int ID_W       = $clog2(SLOT_COUNT + 1);
	localparam int MAX_REPORT = 10;

	typedef struct {
		logic [ID_W-1:0]     id;
		logic [KEY_BITS-1:0] rkey;
		status_t             st;
		logic [ID_W-1:0]     live;
		logic [ID_W-1:0]     size;
	} table_reply_t;

	logic [KEY_BITS-1:0] shadow_keys [SLOT_COUNT];
	int                  shadow_size;
	int                  shadow_live;
	table_reply_t        pending_replies [$];
	table_reply_t        want;
	int                  mismatches;

	// Apply one command to the shadow table and return the reply it should give
	function automatic table_reply_t apply_command(logic [2:0] op, logic [KEY_BITS-1:0] k,
			logic [ID_W-1:0] id);
		table_reply_t r;
		int hole;
		int hit;
		bit id_ok;
		r.id   = '0;
		r.rkey = '0;
		r.st   = ST_IGNORED;
		hole   = 0;
		hit    = 0;
		id_ok  = (id >= 1) && (id <= shadow_size);
		case (op)
		OP_ALLOC: begin
			if (k != '0) begin
				for (int i = 1; i <= shadow_size && hit == 0; i++) begin
					if (shadow_keys[i-1] == k)
						hit = i;
					else if (shadow_keys[i-1] == '0 && hole == 0)
						hole = i;
				end
				if (hit != 0) begin
					r.id = ID_W'(hit);
					r.st = ST_DONE;
				end else if (hole != 0) begin
					shadow_keys[hole-1] = k;
					shadow_live++;
					r.id = ID_W'(hole);
					r.st = ST_DONE;
				end else if (shadow_size < SLOT_COUNT) begin
					shadow_keys[shadow_size] = k;
					shadow_size++;
					shadow_live++;
					r.id = ID_W'(shadow_size);
					r.st = ST_DONE;
				end else begin
					r.st = ST_FULL;
				end
			end
		end
		OP_FREE_ID: begin
			if (id_ok && shadow_keys[id-1] != '0) begin
				shadow_keys[id-1] = '0;
				shadow_live--;
				r.st = ST_DONE;
			end
		end
		OP_FREE_KEY: begin
			// the recorded id only gates the search; the key decides the slot
			if (k != '0 && id_ok) begin
				for (int i = 1; i <= shadow_size && hit == 0; i++) begin
					if (shadow_keys[i-1] == k)
						hit = i;
				end
				if (hit != 0) begin
					shadow_keys[hit-1] = '0;
					shadow_live--;
					r.st = ST_DONE;
				end
			end
		end
		OP_LOOKUP: begin
			if (id_ok && shadow_keys[id-1] != '0) begin
				r.rkey = shadow_keys[id-1];
				r.st   = ST_DONE;
			end
		end
		OP_CLEAR: begin
			// used size is kept
			for (int i = 0; i < SLOT_COUNT; i++)
				shadow_keys[i] = '0;
			shadow_live = 0;
			r.st = ST_DONE;
		end
		default: ;
		endcase
		r.live = ID_W'(shadow_live);
		r.size = ID_W'(shadow_size);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++)
				shadow_keys[i] = '0;
			shadow_size = 0;
			shadow_live = 0;
			pending_replies.delete();
			mismatches = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			// retire the finishing transaction before taking a new one on the same edge
			if (done === 1'b1) begin
				if (pending_replies.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORT)
						$display("%0t: result with no command outstanding", $realtime);
				end else begin
					want = pending_replies.pop_front();
					if (result_id !== want.id || result_key !== want.rkey
							|| status !== want.st || live_count !== want.live
							|| used_size !== want.size) begin
						mismatches++;
						if (mismatches <= MAX_REPORT)
							$display({"%0t: result mismatch (expected/actual) id %0d/%0d",
								" key %h/%h status %0d/%0d live %0d/%0d size %0d/%0d"},
								$realtime, want.id, result_id, want.rkey, result_key,
								want.st, status, want.live, live_count,
								want.size, used_size);
					end
				end
			end
			if (start === 1'b1 && busy === 1'b0)
				pending_replies.push_back(apply_command(operation, key, slot_id));
			fail_count <= mismatches;
			pending    <= pending_replies.size();
		end
	end

endmodule

@@ tb/sv/dedup_id_allocator_top_test.sv @@
`timescale 1ns / 100ps
// Testbench top for the handle table allocator: clock, reset, directed and random
// commands, and the verdict. Depends on dia_pkg, dedup_id_allocator_top and
// dedup_id_allocator_checker.

module dedup_id_allocator_top_test;
	import dia_pkg::*;

	localparam int SLOT_COUNT      = DEF_SLOT_COUNT;
	localparam int KEY_BITS        = DEF_KEY_BITS;
	localparam int ID_W            = $clog2(SLOT_COUNT + 1);
	localparam int OP_CODE_MAX     = (1 << $bits(op_t)) - 1;
	localparam int POOL_SIZE       = SLOT_COUNT * 3 / 2;
	localparam int ITEMS_PER_PHASE = 300;
	localparam int BURST_LEN       = 100;
	localparam int IDLE_MIX [4]    = '{0, 57, 0, 27};

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                start      = 1'b0;
	logic [2:0]          operation  = '0;
	logic [KEY_BITS-1:0] key        = '0;
	logic [ID_W-1:0]     slot_id    = '0;
	logic                busy;
	logic                done;
	logic [ID_W-1:0]     result_id;
	logic [KEY_BITS-1:0] result_key;
	logic [1:0]          status;
	logic [ID_W-1:0]     live_count;
	logic [ID_W-1:0]     used_size;
	int                  fail_count;
	int                  pending;

	int                  idle_pct = 0;
	logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

	dedup_id_allocator_top #(
		.SLOT_COUNT(SLOT_COUNT),
		.KEY_BITS  (KEY_BITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.key       (key),
		.slot_id   (slot_id),
		.done      (done),
		.result_id (result_id),
		.result_key(result_key),
		.status    (status),
		.live_count(live_count),
		.used_size (used_size)
	);

	dedup_id_allocator_checker #(
		.SLOT_COUNT(SLOT_COUNT),
		.KEY_BITS  (KEY_BITS)
	) u_table_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.operation (operation),
		.key       (key),
		.slot_id   (slot_id),
		.done      (done),
		.result_id (result_id),
		.result_key(result_key),
		.status    (status),
		.live_count(live_count),
		.used_size (used_size),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always #1 clk = ~clk;

	initial begin
		#1_500_000;
		$display("== FAIL ==");
		$finish;
	end

	// Hold the command until taken; start drops at random while waiting
	task automatic issue(input logic [2:0] op, input logic [KEY_BITS-1:0] k,
			input logic [ID_W-1:0] id);
		bit taken;
		taken = 1'b0;
		while (!taken) begin
			start     <= ($urandom_range(0, 99) >= idle_pct);
			operation <= op;
			key       <= k;
			slot_id   <= id;
			@(posedge clk);
			taken = start && !busy;
		end
	endtask

	initial begin
		logic [2:0]          op;
		logic [KEY_BITS-1:0] k;
		logic [ID_W-1:0]     id;
		int                  roll;
		int                  counted;
		int                  burst_left;
		bit                  fill_mode;

		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = KEY_BITS'($urandom());
		key_pool[0] = '1;
		key_pool[1] = KEY_BITS'(1);
		key_pool[2] = {1'b1, {(KEY_BITS-1){1'b0}}};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, null key, extremes, duplicates, holes, bad ids
		issue(OP_LOOKUP, '0, '0);
		issue(OP_FREE_ID, '0, ID_W'(1));
		issue(OP_ALLOC, '0, '0);
		issue(OP_ALLOC, '1, '0);
		issue(OP_ALLOC, KEY_BITS'(1), '0);
		issue(OP_ALLOC, '1, '1);
		issue(OP_LOOKUP, '0, ID_W'(1));
		issue(OP_LOOKUP, '1, ID_W'(SLOT_COUNT));
		issue(OP_LOOKUP, '0, '1);
		issue(OP_FREE_ID, '0, ID_W'(1));
		issue(OP_LOOKUP, '0, ID_W'(1));
		issue(OP_FREE_ID, '0, ID_W'(1));
		issue(OP_ALLOC, {1'b1, {(KEY_BITS-1){1'b0}}}, '0);
		issue(OP_FREE_KEY, '0, ID_W'(1));
		issue(OP_FREE_KEY, KEY_BITS'(32'h1234_5678), ID_W'(1));
		issue(OP_FREE_KEY, KEY_BITS'(1), '0);
		issue(OP_FREE_KEY, KEY_BITS'(1), ID_W'(3));
		issue(OP_FREE_KEY, KEY_BITS'(1), ID_W'(2));
		for (int c = OP_CLEAR + 1; c <= OP_CODE_MAX; c++)
			issue(3'(c), '1, ID_W'(1));
		issue(OP_CLEAR, '0, '0);
		issue(OP_CLEAR, '1, '1);
		issue(OP_LOOKUP, '0, ID_W'(1));

		// random: bursts that mostly fill the table and churn bursts, picked at random per burst
		burst_left = 0;
		fill_mode  = 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = IDLE_MIX[ph];
			counted  = 0;
			while (counted < ITEMS_PER_PHASE) begin
				if (burst_left == 0) begin
					fill_mode  = 1'($urandom_range(0, 1));
					burst_left = BURST_LEN;
				end
				burst_left--;
				roll = $urandom_range(0, 99);
				if (fill_mode) begin
					if (roll < 70)      op = OP_ALLOC;
					else if (roll < 78) op = OP_FREE_ID;
					else if (roll < 84) op = OP_FREE_KEY;
					else if (roll < 96) op = OP_LOOKUP;
					else                op = 3'($urandom_range(OP_CLEAR + 1, OP_CODE_MAX));
				end else begin
					if (roll < 40)      op = OP_ALLOC;
					else if (roll < 55) op = OP_FREE_ID;
					else if (roll < 72) op = OP_FREE_KEY;
					else if (roll < 90) op = OP_LOOKUP;
					else if (roll < 94) op = OP_CLEAR;
					else                op = 3'($urandom_range(OP_CLEAR + 1, OP_CODE_MAX));
				end
				roll = $urandom_range(0, 99);
				if (roll < 4)       k = '0;
				else if (roll < 14) k = KEY_BITS'($urandom());
				else                k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
				roll = $urandom_range(0, 99);
				if (roll < 5)       id = '0;
				else if (roll < 12) id = ID_W'($urandom_range(SLOT_COUNT + 1, (1 << ID_W) - 1));
				else                id = ID_W'($urandom_range(1, SLOT_COUNT));
				issue(op, k, id);
				// commands that are dropped outright do not count
				if (op <= OP_CLEAR && !((op == OP_ALLOC || op == OP_FREE_KEY) && k == '0))
					counted++;
			end
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SLOT_COUNT + 16) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
